### sv/truth_value_rule_unit_macros.svh
// Assertion macros shared by the truth value rule unit.
`ifndef TRUTH_VALUE_RULE_UNIT_MACROS_SVH
`define TRUTH_VALUE_RULE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock outside reset.
`define TVRU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clock outside reset.
`define TVRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TVRU_ASSERT_SAME(lbl, ante, cons, msg)
`define TVRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/tvru_pkg.sv
`default_nettype none
package tvru_pkg;

    // Rule codes.
    localparam logic [3:0] FN_AND  = 4'd0;
    localparam logic [3:0] FN_OR   = 4'd1;
    localparam logic [3:0] FN_NOT  = 4'd2;
    localparam logic [3:0] FN_IMPL = 4'd3;
    localparam logic [3:0] FN_MP   = 4'd4;
    localparam logic [3:0] FN_DED  = 4'd5;
    localparam logic [3:0] FN_IND  = 4'd6;
    localparam logic [3:0] FN_ABD  = 4'd7;
    localparam logic [3:0] FN_SIM  = 4'd8;

    // Q1.15 one and the rule constants.
    localparam logic [16:0] Q_ONE  = 17'd32768;
    localparam logic [14:0] K_0P9  = 15'd29491;
    localparam logic [14:0] K_0P85 = 15'd27853;
    localparam logic [14:0] K_0P8  = 15'd26214;
    localparam logic [14:0] K_0P7  = 15'd22938;
    localparam logic [14:0] K_0P6  = 15'd19661;
    localparam logic [14:0] K_0P5  = 15'd16384;

    // Number of quotient bits; also the number of iteration stages.
    localparam int DIV_STEPS = 17;

    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] strength_a;
        logic [15:0] confidence_a;
        logic [31:0] count_a;
        logic [15:0] strength_b;
        logic [15:0] confidence_b;
        logic [31:0] count_b;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_strength;
        logic [15:0] out_confidence;
        logic [31:0] out_count;
    } out_item_t;

    // After the product stage.
    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] prod_s;
        logic [31:0] prod_c;
        logic [15:0] sa;
        logic [15:0] sb;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [31:0] n_sel;
    } front_t;

    // Carried through the divide and square root stages.
    typedef struct packed {
        logic [3:0]  func;
        logic [15:0] s_pre;
        logic [15:0] c_pre;
        logic [31:0] n;
        logic        div_zero;
        logic        div_ovf;
        logic [31:0] p;
        logic [31:0] d;
        logic [16:0] nlo;
        logic [16:0] q;
        logic [33:0] sv;
        logic [17:0] srem;
        logic [16:0] root;
    } iter_t;

    // Clamp a 17-bit value to Q1.15 one.
    function automatic logic [15:0] sat_q15(input logic [16:0] x);
        return (x > Q_ONE) ? Q_ONE[15:0] : x[15:0];
    endfunction

endpackage
`default_nettype wire

### sv/tvru_front.sv
`default_nettype none
module tvru_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire tvru_pkg::in_item_t up_data,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output tvru_pkg::front_t       dn_data
);
    import tvru_pkg::*;

    logic   valid_reg;
    front_t data_reg;
    front_t data_next;
    logic [31:0] n_min;
    logic [31:0] n_max;
    logic [32:0] n_sum;

    // Products and count selection.
    always_comb
    begin
        n_min = (up_data.count_a < up_data.count_b) ? up_data.count_a : up_data.count_b;
        n_max = (up_data.count_a > up_data.count_b) ? up_data.count_a : up_data.count_b;
        n_sum = {1'b0, up_data.count_a} + {1'b0, up_data.count_b};
        data_next.func   = up_data.func;
        data_next.prod_s = up_data.strength_a * up_data.strength_b;
        data_next.prod_c = up_data.confidence_a * up_data.confidence_b;
        data_next.sa     = up_data.strength_a;
        data_next.sb     = up_data.strength_b;
        data_next.ca     = up_data.confidence_a;
        data_next.cb     = up_data.confidence_b;
        case (up_data.func)
            FN_OR:   data_next.n_sel = n_max;
            FN_NOT:  data_next.n_sel = up_data.count_a;
            FN_IND:  data_next.n_sel = n_sum[32:1];
            default: data_next.n_sel = n_min;
        endcase
    end

    // Stage register; it loads whenever it is empty or draining.
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

### sv/tvru_prep.sv
`default_nettype none
module tvru_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire tvru_pkg::front_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output tvru_pkg::iter_t      dn_data
);
    import tvru_pkg::*;

    logic  valid_reg;
    iter_t data_reg;
    iter_t data_next;

    logic [14:0] ks;
    logic [31:0] s_scaled;
    logic [31:0] c_scaled;
    logic [46:0] n_scaled;
    logic [16:0] s_raw;
    logic [16:0] c_raw;
    logic [31:0] c_sum;
    logic [46:0] num_n;
    logic [31:0] den;
    logic        zero;

    // Constant scaling, pass-through values and divider setup.
    always_comb
    begin
        case (up_data.func)
            FN_IND:  ks = K_0P8;
            FN_ABD:  ks = K_0P6;
            default: ks = K_0P85;
        endcase
        s_scaled = up_data.prod_s[31:15] * ks;
        c_scaled = up_data.prod_c[31:15] * K_0P9;
        n_scaled = up_data.n_sel * K_0P8;

        case (up_data.func)
            FN_AND:  s_raw = (up_data.sa < up_data.sb) ? {1'b0, up_data.sa} : {1'b0, up_data.sb};
            FN_OR:   s_raw = (up_data.sa > up_data.sb) ? {1'b0, up_data.sa} : {1'b0, up_data.sb};
            FN_NOT:  s_raw = ({1'b0, up_data.sa} > Q_ONE) ? 17'd0 : Q_ONE - {1'b0, up_data.sa};
            FN_MP,
            FN_DED:  s_raw = up_data.prod_s[31:15];
            FN_IND,
            FN_ABD,
            FN_SIM:  s_raw = s_scaled[31:15];
            default: s_raw = 17'd0;
        endcase

        case (up_data.func)
            FN_NOT:  c_raw = {1'b0, up_data.ca};
            FN_IMPL: c_raw = (up_data.ca < up_data.cb) ? {1'b0, up_data.ca} : {1'b0, up_data.cb};
            FN_DED:  c_raw = c_scaled[31:15];
            default: c_raw = 17'd0;
        endcase

        c_sum = {({1'b0, up_data.ca} + {1'b0, up_data.cb}), 15'd0};
        case (up_data.func)
            FN_IMPL:
            begin
                num_n = {16'd0, up_data.sb, 15'd0};
                den   = {16'd0, up_data.sa};
                zero  = (up_data.sa == 16'd0);
            end
            FN_AND,
            FN_OR:
            begin
                num_n = {up_data.prod_c, 15'd0};
                den   = c_sum - up_data.prod_c;
                zero  = (c_sum <= up_data.prod_c);
            end
            default:
            begin
                num_n = 47'd0;
                den   = 32'd0;
                zero  = 1'b1;
            end
        endcase

        data_next.func     = up_data.func;
        data_next.s_pre    = sat_q15(s_raw);
        data_next.c_pre    = sat_q15(c_raw);
        data_next.n        = (up_data.func == FN_ABD) ? n_scaled[46:15] : up_data.n_sel;
        data_next.div_zero = zero;
        data_next.div_ovf  = ({2'b0, num_n[46:17]} >= den);
        data_next.p        = {2'b0, num_n[46:17]};
        data_next.d        = den;
        data_next.nlo      = num_n[16:0];
        data_next.q        = 17'd0;
        data_next.sv       = {2'b00, up_data.prod_c};
        data_next.srem     = 18'd0;
        data_next.root     = 17'd0;
    end

    // Stage register.
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

### sv/tvru_iter.sv
`default_nettype none
module tvru_iter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire tvru_pkg::iter_t up_data,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output tvru_pkg::iter_t     dn_data
);
    import tvru_pkg::*;

    logic  valid_reg;
    iter_t data_reg;
    iter_t data_next;
    logic [32:0] pp;
    logic [19:0] t;
    logic [19:0] trial;

    // One restoring divide step and one square root digit.
    always_comb
    begin
        data_next = up_data;
        pp = {up_data.p, up_data.nlo[16]};
        if (pp >= {1'b0, up_data.d})
        begin
            data_next.p = 32'(pp - {1'b0, up_data.d});
            data_next.q = {up_data.q[15:0], 1'b1};
        end
        else
        begin
            data_next.p = pp[31:0];
            data_next.q = {up_data.q[15:0], 1'b0};
        end
        data_next.nlo = {up_data.nlo[15:0], 1'b0};

        t     = {up_data.srem, up_data.sv[33:32]};
        trial = {1'b0, up_data.root, 2'b01};
        if (t >= trial)
        begin
            data_next.srem = 18'(t - trial);
            data_next.root = {up_data.root[15:0], 1'b1};
        end
        else
        begin
            data_next.srem = t[17:0];
            data_next.root = {up_data.root[15:0], 1'b0};
        end
        data_next.sv = {up_data.sv[31:0], 2'b00};
    end

    // Stage register.
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

### sv/tvru_back.sv
`default_nettype none
module tvru_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire tvru_pkg::iter_t up_data,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output tvru_pkg::out_item_t  dn_data
);
    import tvru_pkg::*;

    logic      valid_reg;
    out_item_t data_reg;
    out_item_t data_next;
    logic [15:0] q_sat;
    logic [14:0] kc;
    logic [31:0] g_scaled;

    // Final selection, geometric mean scaling and saturation.
    always_comb
    begin
        q_sat = up_data.div_ovf ? Q_ONE[15:0] : sat_q15(up_data.q);
        kc = (up_data.func == FN_IND) ? K_0P7 : K_0P5;
        g_scaled = up_data.root * kc;

        if (up_data.func == FN_IMPL)
            data_next.out_strength = up_data.div_zero ? 16'd0 : q_sat;
        else
            data_next.out_strength = up_data.s_pre;

        case (up_data.func)
            FN_AND,
            FN_OR:   data_next.out_confidence = up_data.div_zero ? 16'd0 : q_sat;
            FN_MP,
            FN_SIM:  data_next.out_confidence = sat_q15(up_data.root);
            FN_IND,
            FN_ABD:  data_next.out_confidence = sat_q15(g_scaled[31:15]);
            default: data_next.out_confidence = up_data.c_pre;
        endcase

        data_next.out_count = (up_data.func > FN_SIM) ? 32'd0 : up_data.n;
    end

    // Output register.
    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule
`default_nettype wire

### sv/truth_value_rule_unit.sv
// Stages from request transfer to result valid: product stage, setup stage,
// 17 divide and square root stages, output stage.
// Throughput: one item per cycle; each stage holds one item and moves on
// whenever the stage after it is empty or draining.
// Reset: rst_n clears all stage valid bits asynchronously; data is not reset.
`default_nettype none
`include "truth_value_rule_unit_macros.svh"
module truth_value_rule_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire tvru_pkg::in_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output tvru_pkg::out_item_t     rsp
);
    import tvru_pkg::*;

    logic   front_valid;
    logic   front_ready;
    front_t front_data;

    logic  chain_valid [0:DIV_STEPS];
    logic  chain_ready [0:DIV_STEPS];
    iter_t chain_data  [0:DIV_STEPS];

    // Products.
    tvru_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .dn_data  (front_data)
    );

    // Scaling and divider setup.
    tvru_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    // Divide and square root stages, one quotient bit and one root bit each.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_iter
        tvru_iter u_iter (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_data  (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_data  (chain_data[i+1])
        );
    end

    // Result selection and output register.
    tvru_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[DIV_STEPS]),
        .up_ready (chain_ready[DIV_STEPS]),
        .up_data  (chain_data[DIV_STEPS]),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn_data  (rsp)
    );

    `TVRU_ASSERT_SAME(a_strength_sat, rsp_valid, rsp.out_strength <= 16'd32768, "strength above one")
    `TVRU_ASSERT_SAME(a_conf_sat, rsp_valid, rsp.out_confidence <= 16'd32768, "confidence above one")
    `TVRU_ASSERT_SAME(a_front_ready, !front_valid, req_ready, "empty first stage refuses a transfer")
    `TVRU_ASSERT_NEXT(a_front_fill, req_valid && req_ready, front_valid, "accepted item lost")

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import tvru_pkg::*;

    // Expected truth values for accepted requests, checked in order.
    class truth_scoreboard;
        out_item_t pending[$];
        int        mismatches;

        // Q1.15 product with truncation.
        function automatic logic [63:0] qprod(logic [63:0] x, logic [63:0] y);
            return (x * y) >> 15;
        endfunction

        // Floor square root by bisection on a 64-bit value.
        function automatic logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] mid;
            lo = 0;
            hi = 64'd4294967295;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid <= v)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        // Combined confidence c1c2 / (c1 + c2 - c1c2); zero when not positive.
        function automatic logic [63:0] conf_merge(logic [63:0] x, logic [63:0] y);
            logic [63:0] num;
            logic [63:0] den;
            num = x * y;
            den = (x + y) << 15;
            if (den <= num)
                return 0;
            return (num << 15) / (den - num);
        endfunction

        function automatic out_item_t predict(in_item_t r);
            logic [63:0] sa;
            logic [63:0] ca;
            logic [63:0] na;
            logic [63:0] sb;
            logic [63:0] cb;
            logic [63:0] nb;
            logic [63:0] s;
            logic [63:0] c;
            logic [63:0] n;
            logic [63:0] nmin;
            out_item_t   o;
            sa = r.strength_a;
            ca = r.confidence_a;
            na = r.count_a;
            sb = r.strength_b;
            cb = r.confidence_b;
            nb = r.count_b;
            s = 0;
            c = 0;
            n = 0;
            nmin = (na < nb) ? na : nb;
            case (r.func)
                FN_AND:
                begin
                    s = (sa < sb) ? sa : sb;
                    c = conf_merge(ca, cb);
                    n = nmin;
                end
                FN_OR:
                begin
                    s = (sa > sb) ? sa : sb;
                    c = conf_merge(ca, cb);
                    n = (na > nb) ? na : nb;
                end
                FN_NOT:
                begin
                    s = (sa > Q_ONE) ? 0 : Q_ONE - sa;
                    c = ca;
                    n = na;
                end
                FN_IMPL:
                begin
                    if (sa != 0)
                    begin
                        s = (sb << 15) / sa;
                        if (s > Q_ONE)
                            s = Q_ONE;
                    end
                    c = (ca < cb) ? ca : cb;
                    n = nmin;
                end
                FN_MP:
                begin
                    s = qprod(sa, sb);
                    c = root_floor(ca * cb);
                    n = nmin;
                end
                FN_DED:
                begin
                    s = qprod(sa, sb);
                    c = qprod(qprod(ca, cb), K_0P9);
                    n = nmin;
                end
                FN_IND:
                begin
                    s = qprod(qprod(sa, sb), K_0P8);
                    c = qprod(root_floor(ca * cb), K_0P7);
                    n = (na + nb) >> 1;
                end
                FN_ABD:
                begin
                    s = qprod(qprod(sa, sb), K_0P6);
                    c = qprod(root_floor(ca * cb), K_0P5);
                    n = qprod(nmin, K_0P8);
                end
                FN_SIM:
                begin
                    s = qprod(qprod(sa, sb), K_0P85);
                    c = root_floor(ca * cb);
                    n = nmin;
                end
                default:
                begin
                end
            endcase
            o.out_strength = (s > Q_ONE) ? Q_ONE[15:0] : s[15:0];
            o.out_confidence = (c > Q_ONE) ? Q_ONE[15:0] : c[15:0];
            o.out_count = (n > 64'hFFFFFFFF) ? 32'hFFFFFFFF : n[31:0];
            return o;
        endfunction

        function void note_request(in_item_t r);
            pending.push_back(predict(r));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.out_strength !== want.out_strength
                || got.out_confidence !== want.out_confidence
                || got.out_count !== want.out_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: s %h/%h c %h/%h n %h/%h (want/got)",
                             want.out_strength, got.out_strength,
                             want.out_confidence, got.out_confidence,
                             want.out_count, got.out_count);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    in_item_t  req;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp;

    truth_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    bit  sending_done;
    longint cycle_count;

    truth_value_rule_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check every result transfer and count cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && rsp_valid && rsp_ready)
            board.check_result(rsp);
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Random Q1.15 value biased toward the legal range and its edges.
    function automatic logic [15:0] rand_q15();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request after a random gap and hold it until its transfer.
    task automatic send_request(in_item_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic send_random(int count);
        in_item_t r;
        repeat (count)
        begin
            r.func = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(8));
            r.strength_a = rand_q15();
            r.confidence_a = rand_q15();
            r.count_a = rand_count();
            r.strength_b = rand_q15();
            r.confidence_b = rand_q15();
            r.count_b = rand_count();
            send_request(r);
        end
    endtask

    task automatic send_directed();
        in_item_t r;
        logic [3:0] f;
        for (int k = 0; k <= 8; k++)
        begin
            f = 4'(k);
            r = '{f, 16'd32768, 16'd32768, 32'hFFFFFFFF, 16'd32768, 16'd32768, 32'hFFFFFFFF};
            send_request(r);
            r = '{f, 16'd12000, 16'd20000, 32'h00018000, 16'd30000, 16'd500, 32'h7FFF0000};
            send_request(r);
        end
        // Zero premise in implication.
        send_request('{FN_IMPL, 16'd0, 16'd100, 32'd5, 16'd9000, 16'd200, 32'd7});
        // Both confidences zero in and, both above one in or.
        send_request('{FN_AND, 16'd100, 16'd0, 32'd1, 16'd200, 16'd0, 32'd2});
        send_request('{FN_OR, 16'hFFFF, 16'hFFFF, 32'd1, 16'hFFFF, 16'hFFFF, 32'd2});
        // Not of a strength above one, and pass-through saturation.
        send_request('{FN_NOT, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'd0, 16'd0, 32'd0});
        // Unused rule codes.
        send_request('{4'hF, 16'd5, 16'd5, 32'd5, 16'd5, 16'd5, 32'd5});
        send_request('{4'h9, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                       32'hFFFFFFFF});
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus in phases of varying idle and stall rates.
    initial
    begin
        board = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        sending_done = 1'b0;
        cycle_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random(130);
        send_idle_pct = 57;
        send_random(130);
        send_idle_pct = 0;
        recv_stall_pct = 57;
        send_random(130);
        send_idle_pct = 28;
        recv_stall_pct = 28;
        send_random(100);
        // Long receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 80;
        send_random(60);
        req_valid <= 1'b0;
        drain();
        repeat (30) @(posedge clk);
        sending_done = 1'b1;
    end

    // Final verdict, or a timeout.
    initial
    begin
        wait (sending_done || cycle_count >= 200000);
        if (!sending_done)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            if (board.mismatches == 0 && board.pending.size() == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/tvru_pkg.sv
sv/tvru_front.sv
sv/tvru_prep.sv
sv/tvru_iter.sv
sv/tvru_back.sv
sv/truth_value_rule_unit.sv
bench/tb_top.sv
